[rtl/owtm_pkg.sv]
// owtm_pkg: word types, opcodes, register indexes and reset values for the
// one-wire bus master core. No dependencies.
`default_nettype none

package owtm_pkg;

   localparam int CFG_WIDTH = 10;
   localparam int CFG_COUNT = 8;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RESET = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_TEMP  = 3'd4;

   localparam logic [2:0] REG_RESET_LOW     = 3'd0;
   localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
   localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
   localparam logic [2:0] REG_PRESENCE_LOW  = 3'd3;
   localparam logic [2:0] REG_SLOT_SHORT    = 3'd4;
   localparam logic [2:0] REG_SLOT_LONG     = 3'd5;
   localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [2:0] REG_READ_RECOVERY = 3'd7;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic               drive_low;
      logic               busy_res;
      logic               done_res;
      logic               presence_fail;
      logic [7:0]         byte_read;
      logic signed [11:0] temperature;
      logic               rejected;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_ticks;
      logic [CFG_WIDTH-1:0] reset_release_ticks;
      logic [CFG_WIDTH-1:0] presence_wait_limit;
      logic [CFG_WIDTH-1:0] presence_low_limit;
      logic [CFG_WIDTH-1:0] slot_short_ticks;
      logic [CFG_WIDTH-1:0] slot_long_ticks;
      logic [CFG_WIDTH-1:0] read_sample_ticks;
      logic [CFG_WIDTH-1:0] read_recovery_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reset_low_ticks:     10'd750,
      reset_release_ticks: 10'd15,
      presence_wait_limit: 10'd200,
      presence_low_limit:  10'd240,
      slot_short_ticks:    10'd2,
      slot_long_ticks:     10'd60,
      read_sample_ticks:   10'd12,
      read_recovery_ticks: 10'd50
   };

   localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0] CMD_CONVERT    = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   localparam logic [7:0]  NEG_HIGH_LIMIT = 8'd7;
   localparam logic [15:0] TEMP_POS_MAX   = 16'd1279;
   localparam logic [15:0] TEMP_NEG_MAX   = 16'd1280;

endpackage

`default_nettype wire

[rtl/one_wire_temp_sensor_master_core.sv]
// one_wire_temp_sensor_master_core: one-wire bus master top level with the
// configuration registers and the result register. Depends on owtm_pkg, owtm_engine.
// The result word of an accepted word is registered and is offered in the cycle after.
// Throughput: one word per cycle unless a held result is stalled; the result register
// lets a new word in while the previous result is taken in the same cycle.
// Reset: synchronous, clears the sequencer to idle, empties the result register
// and loads the default timing registers.
`default_nettype none

module one_wire_temp_sensor_master_core #(
   parameter int TICK_COUNT_WIDTH = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire owtm_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output owtm_pkg::rsp_type      rsp_word,
   input  wire logic              csr_write_enable,
   input  wire logic [2:0]        csr_index,
   input  wire logic [owtm_pkg::CFG_WIDTH-1:0] csr_data
);
   import owtm_pkg::*;

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   owtm_engine #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .cfg    (cfg_ff),
      .rsp    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_RESET_LOW:     cfg_ff.reset_low_ticks     <= csr_data;
            REG_RESET_RELEASE: cfg_ff.reset_release_ticks <= csr_data;
            REG_PRESENCE_WAIT: cfg_ff.presence_wait_limit <= csr_data;
            REG_PRESENCE_LOW:  cfg_ff.presence_low_limit  <= csr_data;
            REG_SLOT_SHORT:    cfg_ff.slot_short_ticks    <= csr_data;
            REG_SLOT_LONG:     cfg_ff.slot_long_ticks     <= csr_data;
            REG_READ_SAMPLE:   cfg_ff.read_sample_ticks   <= csr_data;
            default:           cfg_ff.read_recovery_ticks <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

[rtl/owtm_temp_conv.sv]
// owtm_temp_conv: raw sensor reading to tenths of a degree (x5 >> 3),
// saturated, two's complement. Depends on owtm_pkg.
`default_nettype none

module owtm_temp_conv (
   input  wire logic [7:0]         high_byte,
   input  wire logic [7:0]         low_byte,
   output logic signed [11:0]      temperature
);
   import owtm_pkg::*;

   logic [15:0] raw;
   logic        neg;
   logic [15:0] mag;
   logic [18:0] times5;
   logic [15:0] tenths;
   logic [11:0] mag_sat;

   always_comb begin
      raw    = {high_byte, low_byte};
      neg    = (high_byte > NEG_HIGH_LIMIT);
      mag    = neg ? (16'd0 - raw) : raw;
      times5 = {1'b0, mag, 2'b00} + {3'b000, mag};
      tenths = times5[18:3];
      if (neg) begin
         mag_sat     = (tenths > TEMP_NEG_MAX) ? TEMP_NEG_MAX[11:0] : tenths[11:0];
         temperature = signed'(12'd0 - mag_sat);
      end else begin
         mag_sat     = (tenths > TEMP_POS_MAX) ? TEMP_POS_MAX[11:0] : tenths[11:0];
         temperature = signed'(mag_sat);
      end
   end

endmodule

`default_nettype wire

[rtl/owtm_engine.sv]
// owtm_engine: bus phase sequencer, slot timer and command sequence state.
// Depends on owtm_pkg and owtm_temp_conv.
`default_nettype none

module owtm_engine #(
   parameter int TICK_COUNT_WIDTH = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire owtm_pkg::req_type req,
   input  wire owtm_pkg::cfg_type cfg,
   output owtm_pkg::rsp_type     rsp
);
   import owtm_pkg::*;

   localparam int CMP_W = (TICK_COUNT_WIDTH + 1 > CFG_WIDTH) ? TICK_COUNT_WIDTH + 1 : CFG_WIDTH;

   localparam logic [3:0] STEP_RESET_A     = 4'd0;
   localparam logic [3:0] STEP_SKIP_A      = 4'd1;
   localparam logic [3:0] STEP_CONVERT     = 4'd2;
   localparam logic [3:0] STEP_RESET_B     = 4'd3;
   localparam logic [3:0] STEP_SKIP_B      = 4'd4;
   localparam logic [3:0] STEP_SCRATCH     = 4'd5;
   localparam logic [3:0] STEP_READ_LOW    = 4'd6;
   localparam logic [3:0] STEP_READ_HIGH   = 4'd7;
   localparam logic [3:0] STEP_RESET_ONLY  = 4'd8;
   localparam logic [3:0] STEP_WRITE_ONLY  = 4'd9;
   localparam logic [3:0] STEP_READ_ONLY   = 4'd10;

   typedef enum logic [11:0] {
      PH_IDLE    = 12'b0000_0000_0001,
      PH_RST_LOW = 12'b0000_0000_0010,
      PH_RST_REL = 12'b0000_0000_0100,
      PH_PW_HIGH = 12'b0000_0000_1000,
      PH_PW_LOW  = 12'b0000_0001_0000,
      PH_W1_LOW  = 12'b0000_0010_0000,
      PH_W1_HIGH = 12'b0000_0100_0000,
      PH_W0_LOW  = 12'b0000_1000_0000,
      PH_W0_HIGH = 12'b0001_0000_0000,
      PH_RD_LOW  = 12'b0010_0000_0000,
      PH_RD_WAIT = 12'b0100_0000_0000,
      PH_RD_REC  = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] shift;
   } start_type;

   function automatic phase_type bit_phase(input logic [7:0] shift);
      return shift[0] ? PH_W1_LOW : PH_W0_LOW;
   endfunction

   function automatic start_type start_op(input logic [3:0] step, input logic [7:0] shift);
      start_type s;
      s.shift = shift;
      s.phase = PH_RST_LOW;
      case (step)
         STEP_RESET_A, STEP_RESET_B, STEP_RESET_ONLY: begin
            s.phase = PH_RST_LOW;
         end
         STEP_SKIP_A, STEP_SKIP_B: begin
            s.shift = CMD_SKIP_ROM;
            s.phase = bit_phase(CMD_SKIP_ROM);
         end
         STEP_CONVERT: begin
            s.shift = CMD_CONVERT;
            s.phase = bit_phase(CMD_CONVERT);
         end
         STEP_SCRATCH: begin
            s.shift = CMD_READ_SCRATCH;
            s.phase = bit_phase(CMD_READ_SCRATCH);
         end
         STEP_WRITE_ONLY: begin
            s.phase = bit_phase(shift);
         end
         default: begin
            s.shift = 8'd0;
            s.phase = PH_RD_LOW;
         end
      endcase
      return s;
   endfunction

   phase_type                   phase_ff, phase_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [2:0]                  bit_ff, bit_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [3:0]                  step_ff, step_in;
   logic [7:0]                  low_byte_ff, low_byte_in;
   logic                        presence_ff, presence_in;
   logic signed [11:0]          temp_ff, temp_in;
   logic [7:0]                  byte_held_ff, byte_held_in;

   logic [CFG_WIDTH-1:0]        limit;
   logic [TICK_COUNT_WIDTH:0]   tick_inc;
   logic                        hit;
   logic [TICK_COUNT_WIDTH-1:0] tick_elapse;
   logic                        fin;
   logic                        nb;
   logic                        done;
   logic                        rej;
   logic signed [11:0]          temp_conv;
   start_type                   st;

   owtm_temp_conv u_temp (
      .high_byte   (shift_ff),
      .low_byte    (low_byte_ff),
      .temperature (temp_conv)
   );

   always_comb begin
      case (phase_ff)
         PH_RST_LOW: limit = cfg.reset_low_ticks;
         PH_RST_REL: limit = cfg.reset_release_ticks;
         PH_PW_HIGH: limit = cfg.presence_wait_limit;
         PH_PW_LOW:  limit = cfg.presence_low_limit;
         PH_W1_LOW:  limit = cfg.slot_short_ticks;
         PH_W0_LOW:  limit = cfg.slot_long_ticks;
         PH_W1_HIGH: limit = cfg.slot_long_ticks;
         PH_W0_HIGH: limit = cfg.slot_short_ticks;
         PH_RD_LOW:  limit = cfg.slot_short_ticks;
         PH_RD_WAIT: limit = cfg.read_sample_ticks;
         PH_RD_REC:  limit = cfg.read_recovery_ticks;
         default:    limit = cfg.slot_short_ticks;
      endcase
      tick_inc    = {1'b0, tick_ff} + {{TICK_COUNT_WIDTH{1'b0}}, 1'b1};
      hit         = (CMP_W'(tick_inc) >= CMP_W'(limit)) || (&tick_ff);
      tick_elapse = hit ? '0 : tick_inc[TICK_COUNT_WIDTH-1:0];
   end

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      low_byte_in  = low_byte_ff;
      presence_in  = presence_ff;
      temp_in      = temp_ff;
      byte_held_in = byte_held_ff;
      fin          = 1'b0;
      nb           = 1'b0;
      done         = 1'b0;
      rej          = 1'b0;
      st           = start_op(step_ff, shift_ff);

      if (phase_ff == PH_IDLE) begin
         if (req.opcode inside {OP_RESET, OP_WRITE, OP_READ, OP_TEMP}) begin
            case (req.opcode)
               OP_RESET: step_in = STEP_RESET_ONLY;
               OP_WRITE: step_in = STEP_WRITE_ONLY;
               OP_READ:  step_in = STEP_READ_ONLY;
               default:  step_in = STEP_RESET_A;
            endcase
            if (req.opcode == OP_WRITE) begin
               shift_in = req.data_byte;
            end
            st       = start_op(step_in, shift_in);
            phase_in = st.phase;
            shift_in = st.shift;
            tick_in  = '0;
            bit_in   = 3'd0;
         end
      end else begin
         rej = (req.opcode != OP_TICK);
         case (phase_ff)
            PH_RST_LOW: begin
               tick_in = tick_elapse;
               if (hit) phase_in = PH_RST_REL;
            end
            PH_RST_REL: begin
               tick_in = tick_elapse;
               if (hit) phase_in = PH_PW_HIGH;
            end
            PH_PW_HIGH: begin
               if (!req.line_level) begin
                  tick_in  = '0;
                  phase_in = PH_PW_LOW;
               end else begin
                  tick_in = tick_elapse;
                  if (hit) begin
                     presence_in = 1'b1;
                     fin         = 1'b1;
                  end
               end
            end
            PH_PW_LOW: begin
               if (req.line_level) begin
                  tick_in     = '0;
                  presence_in = 1'b0;
                  fin         = 1'b1;
               end else begin
                  tick_in = tick_elapse;
                  if (hit) begin
                     presence_in = 1'b1;
                     fin         = 1'b1;
                  end
               end
            end
            PH_W1_LOW: begin
               tick_in = tick_elapse;
               if (hit) phase_in = PH_W1_HIGH;
            end
            PH_W0_LOW: begin
               tick_in = tick_elapse;
               if (hit) phase_in = PH_W0_HIGH;
            end
            PH_W1_HIGH, PH_W0_HIGH: begin
               tick_in = tick_elapse;
               if (hit) begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  nb       = 1'b1;
               end
            end
            PH_RD_LOW: begin
               tick_in = tick_elapse;
               if (hit) phase_in = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
               tick_in = tick_elapse;
               if (hit) begin
                  shift_in = {req.line_level, shift_ff[7:1]};
                  phase_in = PH_RD_REC;
               end
            end
            PH_RD_REC: begin
               tick_in = tick_elapse;
               if (hit) nb = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase

         // next bit of the byte, or the end of this byte
         if (nb) begin
            if (&bit_ff) begin
               fin = 1'b1;
            end else begin
               bit_in  = bit_ff + 3'd1;
               tick_in = '0;
               if (phase_ff == PH_RD_REC) begin
                  phase_in = PH_RD_LOW;
               end else begin
                  phase_in = bit_phase(shift_in);
               end
            end
         end

         if (fin) begin
            if (step_ff == STEP_READ_LOW)  low_byte_in  = shift_in;
            if (step_ff == STEP_READ_HIGH) temp_in      = temp_conv;
            if (step_ff == STEP_READ_ONLY) byte_held_in = shift_in;
            if (step_ff < STEP_READ_HIGH) begin
               step_in  = step_ff + 4'd1;
               st       = start_op(step_in, shift_in);
               phase_in = st.phase;
               shift_in = st.shift;
               tick_in  = '0;
               bit_in   = 3'd0;
            end else begin
               phase_in = PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
            end
         end
      end

      rsp.drive_low     = (phase_in inside {PH_RST_LOW, PH_W1_LOW, PH_W0_LOW, PH_RD_LOW});
      rsp.busy_res      = (phase_in != PH_IDLE);
      rsp.done_res      = done;
      rsp.presence_fail = presence_in;
      rsp.byte_read     = byte_held_in;
      rsp.temperature   = temp_in;
      rsp.rejected      = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         step_ff      <= STEP_RESET_A;
         low_byte_ff  <= 8'd0;
         presence_ff  <= 1'b0;
         temp_ff      <= 12'sd0;
         byte_held_ff <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         step_ff      <= step_in;
         low_byte_ff  <= low_byte_in;
         presence_ff  <= presence_in;
         temp_ff      <= temp_in;
         byte_held_ff <= byte_held_in;
      end
   end

   a_idle_no_reject: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_IDLE) |-> !rsp.rejected)
      else $error("command rejected while idle");

   a_command_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_IDLE) &&
      (req.opcode == OP_RESET || req.opcode == OP_WRITE ||
       req.opcode == OP_READ || req.opcode == OP_TEMP) |=> (phase_ff != PH_IDLE))
      else $error("command did not leave idle");

   a_presence_seen: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_PW_LOW) && req.line_level |=> !presence_ff)
      else $error("presence pulse end not recorded");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && rsp.done_res |=> (phase_ff == PH_IDLE) && (tick_ff == '0))
      else $error("completion did not return to idle");

endmodule

`default_nettype wire

[dv/tb.sv]
// tb: self-checking bench for one_wire_temp_sensor_master_core, with a cycle-true bus model,
// a scripted sensor on the line and random idling on both word channels
// depends on owtm_pkg and one_wire_temp_sensor_master_core
module tb;
   import owtm_pkg::*;

   localparam int TICK_BITS = 10;
   localparam int unsigned TICK_COUNT_MAX = (1 << TICK_BITS) - 1;
   localparam int QUIET_LIMIT = 5000;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;
   localparam logic [1:0][15:0] RAW_CORNERS = {16'h07FF, 16'h0800};

   typedef enum logic [3:0] {
      BUS_IDLE, BUS_RESET_LOW, BUS_RESET_RELEASE, BUS_WAIT_PRESENCE, BUS_PRESENCE_LOW,
      BUS_WRITE1_LOW, BUS_WRITE1_HIGH, BUS_WRITE0_LOW, BUS_WRITE0_HIGH,
      BUS_READ_LOW, BUS_READ_SAMPLE, BUS_READ_RECOVER
   } bus_phase_type;

   typedef enum logic [3:0] {
      SEQ_RESET_A, SEQ_SKIP_A, SEQ_CONVERT, SEQ_RESET_B, SEQ_SKIP_B, SEQ_READ_SCRATCH,
      SEQ_TEMP_LOW, SEQ_TEMP_HIGH, SEQ_RESET_ONLY, SEQ_WRITE_ONLY, SEQ_READ_ONLY
   } seq_step_type;

   typedef enum logic [1:0] {SLAVE_ANSWERS, SLAVE_ABSENT, SLAVE_STUCK} slave_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   // bus model state
   logic [CFG_WIDTH-1:0] timing [CFG_COUNT];
   logic [CFG_WIDTH-1:0] next_timing [CFG_COUNT];
   bus_phase_type bus_phase = BUS_IDLE;
   seq_step_type bus_seq = SEQ_RESET_A;
   int unsigned bus_ticks = 0;
   logic [2:0] bus_bit = '0;
   logic [7:0] bus_shift = '0;
   logic [7:0] bus_low_byte = '0;
   logic [7:0] bus_byte = '0;
   logic bus_presence = 1'b0;
   logic [11:0] bus_temp = '0;
   logic bus_done = 1'b0;

   // sensor behaviour on the line
   slave_type slave_mode = SLAVE_ANSWERS;
   logic [7:0] read_data = '0;
   logic [15:0] sensor_raw = '0;

   req_type outgoing_words [$];
   rsp_type predicted_status [$];
   int unsigned words_queued = 0;
   bit steady = 1'b0;
   bit failed = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int quiet_cycles = 0;
   rsp_type want;

   one_wire_temp_sensor_master_core #(.TICK_COUNT_WIDTH(TICK_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit tick_elapsed(input logic [CFG_WIDTH-1:0] limit);
      int unsigned n;
      n = bus_ticks + 1;
      if (n >= limit || n > TICK_COUNT_MAX) begin
         bus_ticks = 0;
         return 1'b1;
      end
      bus_ticks = n;
      return 1'b0;
   endfunction

   function automatic void begin_write_slot();
      bus_ticks = 0;
      bus_phase = bus_shift[0] ? BUS_WRITE1_LOW : BUS_WRITE0_LOW;
   endfunction

   function automatic void begin_stage();
      bus_ticks = 0;
      bus_bit = '0;
      case (bus_seq)
         SEQ_RESET_A, SEQ_RESET_B, SEQ_RESET_ONLY: bus_phase = BUS_RESET_LOW;
         SEQ_SKIP_A, SEQ_SKIP_B: begin
            bus_shift = CMD_SKIP_ROM;
            begin_write_slot();
         end
         SEQ_CONVERT: begin
            bus_shift = CMD_CONVERT;
            begin_write_slot();
         end
         SEQ_READ_SCRATCH: begin
            bus_shift = CMD_READ_SCRATCH;
            begin_write_slot();
         end
         SEQ_WRITE_ONLY: begin_write_slot();
         default: begin
            bus_shift = '0;
            bus_phase = BUS_READ_LOW;
         end
      endcase
   endfunction

   function automatic void end_stage();
      logic [15:0] raw;
      logic [15:0] mag;
      logic [18:0] tenths;
      logic neg;
      if (bus_seq == SEQ_TEMP_LOW) bus_low_byte = bus_shift;
      if (bus_seq == SEQ_TEMP_HIGH) begin
         raw = {bus_shift, bus_low_byte};
         neg = bus_shift > NEG_HIGH_LIMIT;
         mag = neg ? -raw : raw;
         tenths = (19'(mag) * 19'd5) >> 3;
         if (neg && tenths > 19'(TEMP_NEG_MAX)) tenths = 19'(TEMP_NEG_MAX);
         if (!neg && tenths > 19'(TEMP_POS_MAX)) tenths = 19'(TEMP_POS_MAX);
         bus_temp = neg ? -tenths[11:0] : tenths[11:0];
      end
      if (bus_seq == SEQ_READ_ONLY) bus_byte = bus_shift;
      if (bus_seq < SEQ_TEMP_HIGH) begin
         bus_seq = seq_step_type'(bus_seq + 1);
         begin_stage();
      end else begin
         bus_phase = BUS_IDLE;
         bus_ticks = 0;
         bus_done = 1'b1;
      end
   endfunction

   function automatic void next_slot();
      if (bus_bit >= 3'd7) begin
         end_stage();
      end else begin
         bus_bit++;
         if (bus_phase == BUS_READ_RECOVER) begin
            bus_ticks = 0;
            bus_phase = BUS_READ_LOW;
         end else begin
            begin_write_slot();
         end
      end
   endfunction

   function automatic rsp_type bus_master_step(input req_type word);
      rsp_type res;
      logic turned_away;
      turned_away = 1'b0;
      bus_done = 1'b0;
      if (bus_phase == BUS_IDLE) begin
         case (word.opcode)
            OP_RESET: begin
               bus_seq = SEQ_RESET_ONLY;
               begin_stage();
            end
            OP_WRITE: begin
               bus_seq = SEQ_WRITE_ONLY;
               bus_shift = word.data_byte;
               begin_stage();
            end
            OP_READ: begin
               bus_seq = SEQ_READ_ONLY;
               begin_stage();
            end
            OP_TEMP: begin
               bus_seq = SEQ_RESET_A;
               begin_stage();
            end
            default: ;
         endcase
      end else begin
         turned_away = (word.opcode != OP_TICK);
         case (bus_phase)
            BUS_RESET_LOW:
               if (tick_elapsed(timing[REG_RESET_LOW])) bus_phase = BUS_RESET_RELEASE;
            BUS_RESET_RELEASE:
               if (tick_elapsed(timing[REG_RESET_RELEASE])) bus_phase = BUS_WAIT_PRESENCE;
            BUS_WAIT_PRESENCE:
               if (!word.line_level) begin
                  bus_ticks = 0;
                  bus_phase = BUS_PRESENCE_LOW;
               end else if (tick_elapsed(timing[REG_PRESENCE_WAIT])) begin
                  bus_presence = 1'b1;
                  end_stage();
               end
            BUS_PRESENCE_LOW:
               if (word.line_level) begin
                  bus_ticks = 0;
                  bus_presence = 1'b0;
                  end_stage();
               end else if (tick_elapsed(timing[REG_PRESENCE_LOW])) begin
                  bus_presence = 1'b1;
                  end_stage();
               end
            BUS_WRITE1_LOW:
               if (tick_elapsed(timing[REG_SLOT_SHORT])) bus_phase = BUS_WRITE1_HIGH;
            BUS_WRITE0_LOW:
               if (tick_elapsed(timing[REG_SLOT_LONG])) bus_phase = BUS_WRITE0_HIGH;
            BUS_WRITE1_HIGH, BUS_WRITE0_HIGH:
               if (tick_elapsed(bus_phase == BUS_WRITE1_HIGH ? timing[REG_SLOT_LONG]
                                                              : timing[REG_SLOT_SHORT])) begin
                  bus_shift = bus_shift >> 1;
                  next_slot();
               end
            BUS_READ_LOW:
               if (tick_elapsed(timing[REG_SLOT_SHORT])) bus_phase = BUS_READ_SAMPLE;
            BUS_READ_SAMPLE:
               if (tick_elapsed(timing[REG_READ_SAMPLE])) begin
                  bus_shift = {word.line_level, bus_shift[7:1]};
                  bus_phase = BUS_READ_RECOVER;
               end
            BUS_READ_RECOVER:
               if (tick_elapsed(timing[REG_READ_RECOVERY])) next_slot();
            default: ;
         endcase
      end
      res.drive_low = (bus_phase == BUS_RESET_LOW) || (bus_phase == BUS_WRITE1_LOW) ||
                      (bus_phase == BUS_WRITE0_LOW) || (bus_phase == BUS_READ_LOW);
      res.busy_res = (bus_phase != BUS_IDLE);
      res.done_res = bus_done;
      res.presence_fail = bus_presence;
      res.byte_read = bus_byte;
      res.temperature = bus_temp;
      res.rejected = turned_away;
      return res;
   endfunction

   // the sensor answers on the line from the bus phase before this tick
   function automatic void queue_word(input logic [2:0] op, input logic [7:0] data);
      req_type word;
      logic [7:0] reply;
      reply = (bus_seq == SEQ_TEMP_LOW) ? sensor_raw[7:0] :
              (bus_seq == SEQ_TEMP_HIGH) ? sensor_raw[15:8] : read_data;
      word.opcode = op;
      word.data_byte = data;
      case (bus_phase)
         BUS_WAIT_PRESENCE:
            word.line_level = (slave_mode == SLAVE_ABSENT) ? 1'b1 :
                              (slave_mode == SLAVE_STUCK) ? 1'b0 : ($urandom_range(0, 2) != 0);
         BUS_PRESENCE_LOW:
            word.line_level = (slave_mode == SLAVE_ANSWERS) && ($urandom_range(0, 2) == 0);
         BUS_READ_SAMPLE: word.line_level = reply[bus_bit];
         default: word.line_level = 1'($urandom_range(0, 1));
      endcase
      outgoing_words.push_back(word);
      predicted_status.push_back(bus_master_step(word));
      words_queued++;
   endfunction

   function automatic void run_command(input logic [2:0] op, input logic [7:0] data,
                                       input bit meddle);
      logic [2:0] busy_op;
      queue_word(op, data);
      while (bus_phase != BUS_IDLE) begin
         busy_op = OP_TICK;
         if (meddle && $urandom_range(0, 15) == 0)
            busy_op = 3'($urandom_range(OP_RESET, OP_SPARE_LAST));
         queue_word(busy_op, 8'($urandom));
      end
   endfunction

   function automatic void random_traffic(input int unsigned target);
      int unsigned stop_at;
      int unsigned pick;
      logic [2:0] op;
      logic [11:0] reading;
      stop_at = words_queued + target;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 9);
         slave_mode = (pick < 8) ? SLAVE_ANSWERS : (pick == 8) ? SLAVE_ABSENT : SLAVE_STUCK;
         read_data = 8'($urandom);
         reading = 12'($urandom);
         sensor_raw = $urandom_range(0, 1) ? 16'($urandom) : {{4{reading[11]}}, reading};
         pick = $urandom_range(0, 99);
         if (pick < 15) op = OP_RESET;
         else if (pick < 40) op = OP_WRITE;
         else if (pick < 65) op = OP_READ;
         else if (pick < 85) op = OP_TEMP;
         else if (pick < 93) op = OP_TICK;
         else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         run_command(op, 8'($urandom), 1'($urandom_range(0, 1)));
      end
   endfunction

   function automatic int unsigned draw_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 30);
      return $urandom_range(31, 120);
   endfunction

   function automatic void fill_timing(input logic [CFG_WIDTH-1:0] value);
      for (int i = 0; i < CFG_COUNT; i++) next_timing[i] = value;
   endfunction

   task automatic load_timing();
      for (int i = 0; i < CFG_COUNT; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= next_timing[i];
         timing[i] = next_timing[i];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle();
      while (outgoing_words.size() != 0 || predicted_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [11:0] expected_value,
                              input logic [11:0] actual_value);
      if (expected_value !== actual_value) begin
         failed = 1'b1;
         $display("%0t %s: expected %h, got %h", $time, name, expected_value, actual_value);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            outgoing_words.delete(0);
            send_gap = draw_gap();
         end
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && outgoing_words.size() != 0) begin
               req_valid <= 1'b1;
               req_word <= outgoing_words[0];
            end else begin
               req_valid <= 1'b0;
               if (send_gap != 0) send_gap--;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_status.size() == 0) begin
               check_field("unexpected word", '0, 12'hFFF);
            end else begin
               want = predicted_status.pop_front();
               check_field("drive_low", want.drive_low, rsp_word.drive_low);
               check_field("busy_res", want.busy_res, rsp_word.busy_res);
               check_field("done_res", want.done_res, rsp_word.done_res);
               check_field("presence_fail", want.presence_fail, rsp_word.presence_fail);
               check_field("byte_read", want.byte_read, rsp_word.byte_read);
               check_field("temperature", want.temperature, rsp_word.temperature);
               check_field("rejected", want.rejected, rsp_word.rejected);
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = draw_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("one_wire_temp_sensor_master_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < CFG_COUNT; i++)
         timing[i] = CFG_RESET[(CFG_COUNT-1-i)*CFG_WIDTH +: CFG_WIDTH];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle words straight after reset: spare codes and plain ticks
      for (logic [2:0] op = OP_SPARE_FIRST; op != OP_TICK; op++) run_command(op, 8'hFF, 1'b0);
      run_command(OP_TICK, 8'h00, 1'b0);
      settle();

      // directed words with the shortest slots
      fill_timing(10'd1);
      load_timing();
      slave_mode = SLAVE_ANSWERS;
      run_command(OP_WRITE, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'hFF, 1'b0);
      read_data = 8'h00;
      run_command(OP_READ, 8'h00, 1'b0);
      read_data = 8'hFF;
      run_command(OP_READ, 8'hFF, 1'b0);
      run_command(OP_RESET, 8'h00, 1'b0);
      slave_mode = SLAVE_ABSENT;
      run_command(OP_RESET, 8'h00, 1'b0);
      slave_mode = SLAVE_STUCK;
      run_command(OP_RESET, 8'h00, 1'b0);
      slave_mode = SLAVE_ANSWERS;
      for (int i = 0; i < 2; i++) begin
         sensor_raw = RAW_CORNERS[i];
         run_command(OP_TEMP, 8'h00, i == 1);
      end
      settle();

      for (int k = 0; k < 2; k++) begin
         steady = (k == 0);
         for (int i = 0; i < CFG_COUNT; i++)
            next_timing[i] = ($urandom_range(0, 7) == 0) ? CFG_WIDTH'($urandom_range(3, 6))
                                                         : CFG_WIDTH'($urandom_range(0, 2));
         load_timing();
         random_traffic(60);
         settle();
      end

      if (!failed) begin
         $display("one_wire_temp_sensor_master_core regression: pass");
      end else begin
         $display("one_wire_temp_sensor_master_core regression: fail");
      end
      $finish;
   end
endmodule
